// ===== sv/tetp_pkg.sv =====
// Package: shared constants and types for the touch event to pointer block.
`timescale 1ns / 1ps
package tetp_pkg;
    localparam int SLOTS_DEF   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_W       = 13;
    localparam int SIZE_W      = 14;
    localparam logic [13:0] MAX_SCREEN = 14'd8192;

    localparam logic [4:0] EVT_SYN = 5'd0;
    localparam logic [4:0] EVT_KEY = 5'd1;
    localparam logic [4:0] EVT_REL = 5'd2;
    localparam logic [4:0] EVT_ABS = 5'd3;

    localparam logic [15:0] CODE_X          = 16'h0000;
    localparam logic [15:0] CODE_Y          = 16'h0001;
    localparam logic [15:0] CODE_MT_SLOT    = 16'h002f;
    localparam logic [15:0] CODE_MT_POS_X   = 16'h0035;
    localparam logic [15:0] CODE_MT_POS_Y   = 16'h0036;
    localparam logic [15:0] CODE_MT_TRACK   = 16'h0039;
    localparam logic [15:0] CODE_BTN_LEFT   = 16'h0110;
    localparam logic [15:0] CODE_BTN_RIGHT  = 16'h0111;
    localparam logic [15:0] CODE_BTN_MIDDLE = 16'h0112;
    localparam logic [15:0] CODE_BTN_TOUCH  = 16'h014a;
    localparam logic [15:0] CODE_SYNC_RPT   = 16'h0000;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MT_EN  = 3'd2;
    localparam logic [2:0] CFG_ABS_X  = 3'd3;
    localparam logic [2:0] CFG_ABS_Y  = 3'd4;
    localparam logic [2:0] CFG_MT_X   = 3'd5;
    localparam logic [2:0] CFG_MT_Y   = 3'd6;

    localparam logic [1:0] KIND_POINTER = 2'd0;
    localparam logic [1:0] KIND_BUTTON  = 2'd1;
    localparam logic [1:0] KIND_KEY     = 2'd2;
    localparam logic [1:0] KIND_SYNC    = 2'd3;

    // one result beat, before packing
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] event_code;
        logic [31:0] event_value;
        logic [12:0] px;
        logic [12:0] py;
        logic        down;
        logic        last;
    } result_t;

    function automatic logic [13:0] eff_size(input logic [13:0] s);
        if (s == 14'd0) return 14'd1;
        if (s > MAX_SCREEN) return MAX_SCREEN;
        return s;
    endfunction
endpackage

// ===== sv/tetp_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tetp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [45:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [12:0] quotient
);
    logic [45:0] q_reg;
    logic [33:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial;
    logic        fits;

    assign trial    = {rem_reg[32:0], q_reg[45]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign quotient = q_reg[12:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd46;
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? trial - {1'b0, dvs_reg} : trial;
                q_reg   <= {q_reg[44:0], fits};
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/touch_event_to_pointer.sv =====
// Top level: event decoder, slot position memory, divider and result queue.
`timescale 1ns / 1ps
// touch_event_to_pointer
// Input beats (s_axis) carry one evdev event: op, code, value. Result beats
// (m_axis) carry pointer, button, key and sync reports; tlast marks the
// final result of one event. The configuration port writes screen size,
// multitouch enable and four axis ranges; writing a size recenters the pointer.
// Relative, slot and ignored events finish in S_IDLE, a key event sends one
// result. Absolute position events run the 46-step divider that scales
// (v - min) * (size - 1) / (max - min); a degenerate axis skips the divider.
// A sync report goes straight to S_SYN, or with multitouch on and a slot
// active first scans the active mask, then reads the chosen slot from the
// position memory (a registered read) in S_RD.
// Slot positions live in two synchronous memories; per-slot written bits make
// never-written or degenerate slots read as zero, so no clearing pass is run.
// Reset: pointer centered on an 800x480 screen, no slot selected, mask clear.
// A stalled receiver holds up to three results in the output queue; the
// block takes no new event until its results are all sent.
module touch_event_to_pointer
    import tetp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,  // op[4:0], code[20:5], value[52:21]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,  // kind[1:0], event_code[17:2],
                                            // event_value[49:18], pointer_x_out[62:50],
                                            // pointer_y_out[75:63], down[76]
    output logic                  m_tlast
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_SCAN, S_RD, S_SYN, S_OUT
    } state_t;

    state_t state_reg;
    logic [13:0] sw_reg, sh_reg;
    logic        mt_reg;
    logic [63:0] rx_reg, ry_reg, mx_reg, my_reg;
    logic [12:0] px_reg, py_reg;
    logic [SW-1:0] cur_reg;
    logic        slot_ok_reg;
    logic [SLOTS-1:0] act_reg, wrx_reg, wry_reg;
    logic        touch_reg;
    logic [1:0]  dst_reg;   // 0 px,1 py,2 slot x,3 slot y
    logic [SW-1:0] scan_reg;

    logic [12:0] memx [SLOTS];
    logic [12:0] memy [SLOTS];
    logic [12:0] rdx_reg, rdy_reg;
    logic        mem_we;
    logic [12:0] mem_wd;

    result_t q_reg [3];
    logic [1:0] qn_reg, qh_reg;

    // divider setup
    logic        div_start, div_done;
    logic [45:0] div_num;
    logic [32:0] div_den;
    logic [12:0] div_q;
    tetp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(div_den), .done(div_done), .quotient(div_q));

    logic [4:0]  in_op;
    logic [15:0] in_code;
    logic signed [31:0] in_val;
    assign in_op   = s_tdata[4:0];
    assign in_code = s_tdata[20:5];
    assign in_val  = s_tdata[52:21];

    // absolute scaling operands for the incoming event
    logic [63:0] rng;
    logic [13:0] sz;
    logic signed [32:0] mn, mx, vc;
    logic [32:0] span, off;
    logic degen;
    always_comb begin
        rng = rx_reg; sz = eff_size(sw_reg);
        if (in_code == CODE_Y) begin rng = ry_reg; sz = eff_size(sh_reg); end
        else if (in_code == CODE_MT_POS_X) rng = mx_reg;
        else if (in_code == CODE_MT_POS_Y) begin rng = my_reg; sz = eff_size(sh_reg); end
        mn = {rng[31], rng[31:0]};
        mx = {rng[63], rng[63:32]};
        vc = {in_val[31], in_val};
        if (vc < mn) vc = mn;
        if (vc > mx) vc = mx;
        degen = (sz <= 14'd1) || (mx <= mn);
        span = 33'(mx - mn);
        off  = 33'(vc - mn);
    end
    logic [13:0] szm1;
    assign szm1 = sz - 14'd1;
    // one multiplier, 33 x 13
    assign div_num = 46'(off * szm1[12:0]);
    assign div_den = span;

    // relative move
    logic signed [34:0] rel_n, rel_hi;
    logic [12:0] rel_res;
    always_comb begin
        if (in_code == CODE_Y) begin
            rel_n  = 35'(signed'({1'b0, py_reg})) + 35'(in_val);
            rel_hi = 35'(signed'({1'b0, eff_size(sh_reg)})) - 35'sd1;
        end else begin
            rel_n  = 35'(signed'({1'b0, px_reg})) + 35'(in_val);
            rel_hi = 35'(signed'({1'b0, eff_size(sw_reg)})) - 35'sd1;
        end
        if (rel_n < 0) rel_n = '0;
        if (rel_n > rel_hi) rel_n = rel_hi;
        rel_res = rel_n[12:0];
    end

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // absolute event that goes through scaling; operands are live only
    // while the beat is on the bus, so the divider latches at acceptance
    logic abs_scale;
    assign abs_scale = in_code == CODE_X || in_code == CODE_Y ||
                       (mt_reg && slot_ok_reg && (in_code == CODE_MT_POS_X ||
                                                  in_code == CODE_MT_POS_Y));
    assign div_start = accept && (in_op == EVT_ABS) && abs_scale && !degen;

    logic is_btn;
    assign is_btn = in_code == CODE_BTN_LEFT || in_code == CODE_BTN_RIGHT ||
                    in_code == CODE_BTN_MIDDLE || in_code == CODE_BTN_TOUCH;

    // output queue
    result_t head;
    assign head     = q_reg[qh_reg];
    assign m_tvalid = (state_reg == S_OUT) && (qn_reg != 2'd0);
    assign m_tlast  = head.last;
    assign m_tdata  = {3'd0, head.down, head.py, head.px, head.event_value,
                       head.event_code, head.kind};

    // memory writes
    assign mem_we = (state_reg == S_DIV) && div_done && dst_reg[1];
    assign mem_wd = div_q;
    always_ff @(posedge aclk) begin
        if (mem_we && !dst_reg[0]) memx[cur_reg] <= mem_wd;
        if (mem_we &&  dst_reg[0]) memy[cur_reg] <= mem_wd;
        rdx_reg <= memx[scan_reg];
        rdy_reg <= memy[scan_reg];
    end

    logic any_act;
    assign any_act = |act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sw_reg <= 14'd800; sh_reg <= 14'd480; mt_reg <= 1'b0;
            rx_reg <= '0; ry_reg <= '0; mx_reg <= '0; my_reg <= '0;
            px_reg <= 13'd400; py_reg <= 13'd240;
            cur_reg <= '0; slot_ok_reg <= 1'b0;
            act_reg <= '0; wrx_reg <= '0; wry_reg <= '0;
            touch_reg <= 1'b0; qn_reg <= '0; qh_reg <= '0;
            scan_reg <= '0; dst_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WIDTH: begin
                        sw_reg <= cfg_data[13:0];
                        px_reg <= 13'(eff_size(cfg_data[13:0]) >> 1);
                    end
                    CFG_HEIGHT: begin
                        sh_reg <= cfg_data[13:0];
                        py_reg <= 13'(eff_size(cfg_data[13:0]) >> 1);
                    end
                    CFG_MT_EN: mt_reg <= cfg_data[0];
                    CFG_ABS_X: rx_reg <= cfg_data;
                    CFG_ABS_Y: ry_reg <= cfg_data;
                    CFG_MT_X:  mx_reg <= cfg_data;
                    CFG_MT_Y:  my_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: if (accept) begin
                    qh_reg <= '0;
                    if (in_op == EVT_ABS) begin
                        if (mt_reg && in_code == CODE_MT_SLOT) begin
                            slot_ok_reg <= !in_val[31] && (in_val < 32'(SLOTS));
                            cur_reg <= in_val[SW-1:0];
                        end else if (mt_reg && in_code == CODE_MT_TRACK && slot_ok_reg) begin
                            act_reg[cur_reg] <= !in_val[31];
                        end else if (abs_scale) begin
                            dst_reg <= (in_code == CODE_X) ? 2'd0 :
                                       (in_code == CODE_Y) ? 2'd1 :
                                       (in_code == CODE_MT_POS_X) ? 2'd2 : 2'd3;
                            if (degen) begin
                                // degenerate axis: zero pointer or clear slot written bit
                                if (in_code == CODE_X) px_reg <= '0;
                                else if (in_code == CODE_Y) py_reg <= '0;
                                else if (in_code == CODE_MT_POS_X) wrx_reg[cur_reg] <= 1'b0;
                                else wry_reg[cur_reg] <= 1'b0;
                            end else begin
                                state_reg <= S_DIV;
                            end
                        end
                    end else if (in_op == EVT_REL) begin
                        if (in_code == CODE_X) px_reg <= rel_res;
                        else if (in_code == CODE_Y) py_reg <= rel_res;
                    end else if (in_op == EVT_KEY) begin
                        q_reg[0] <= '{kind: is_btn ? KIND_BUTTON : KIND_KEY,
                                      event_code: in_code, event_value: in_val,
                                      px: px_reg, py: py_reg,
                                      down: in_val != 32'd0, last: 1'b1};
                        qn_reg <= 2'd1;
                        state_reg <= S_OUT;
                    end else if (in_op == EVT_SYN && in_code == CODE_SYNC_RPT) begin
                        scan_reg <= '0;
                        state_reg <= (mt_reg && any_act) ? S_SCAN : S_SYN;
                    end
                end
                S_DIV: if (div_done) begin
                    state_reg <= S_IDLE;
                    case (dst_reg)
                        2'd0: px_reg <= div_q;
                        2'd1: py_reg <= div_q;
                        2'd2: wrx_reg[cur_reg] <= 1'b1;
                        default: wry_reg[cur_reg] <= 1'b1;
                    endcase
                end
                S_SCAN: begin
                    if (act_reg[scan_reg]) state_reg <= S_RD;
                    else scan_reg <= scan_reg + SW'(1);
                end
                S_RD: state_reg <= S_SYN;  // memory read latency
                S_SYN: begin
                    logic [12:0] nx, ny;
                    nx = px_reg; ny = py_reg;
                    if (mt_reg && any_act) begin
                        nx = wrx_reg[scan_reg] ? rdx_reg : '0;
                        ny = wry_reg[scan_reg] ? rdy_reg : '0;
                    end
                    px_reg <= nx; py_reg <= ny;
                    q_reg[0] <= '{kind: KIND_POINTER, event_code: '0, event_value: '0,
                                  px: nx, py: ny, down: 1'b0, last: 1'b0};
                    if (mt_reg && touch_reg != any_act) begin
                        touch_reg <= any_act;
                        q_reg[1] <= '{kind: KIND_BUTTON, event_code: CODE_BTN_TOUCH,
                                      event_value: {31'd0, any_act}, px: nx, py: ny,
                                      down: any_act, last: 1'b0};
                        q_reg[2] <= '{kind: KIND_SYNC, event_code: CODE_SYNC_RPT,
                                      event_value: '0, px: nx, py: ny,
                                      down: 1'b0, last: 1'b1};
                        qn_reg <= 2'd3;
                    end else begin
                        q_reg[1] <= '{kind: KIND_SYNC, event_code: CODE_SYNC_RPT,
                                      event_value: '0, px: nx, py: ny,
                                      down: 1'b0, last: 1'b1};
                        qn_reg <= 2'd2;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) begin
                    qh_reg <= qh_reg + 2'd1;
                    qn_reg <= qn_reg - 2'd1;
                    if (qn_reg == 2'd1) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/tetp_checker.sv =====
// Port-level checker for the touch event to pointer block, with its bind.
`timescale 1ns / 1ps
module tetp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);
    import tetp_pkg::*;

    // no new event taken while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with results pending");
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed under stall");
    // sync beat always ends its event
    a_sync_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_SYNC |-> m_tlast) else $error("sync without last");
    // pointer beat is never the last one
    a_ptr_notlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_POINTER |-> !m_tlast)
        else $error("pointer beat last");
endmodule

bind touch_event_to_pointer tetp_checker u_tetp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast));
